>>> rtl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// shared types, constants and helpers for the code block cache guard
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int ENTRY_AW  = 12;
    localparam int PAGE_AW   = 16;
    localparam int COUNT_W   = 13;
    localparam int TRACE_MAX = 64;
    localparam logic [31:0] SPAN = 32'((TRACE_MAX + 1) * 2);
    localparam logic [31:0] WIN  = 32'd36;
    localparam int PAGE_LSB  = 10;
    localparam int BANK_LSB  = 24;
    localparam logic [7:0] BANK_A = 8'd2;
    localparam logic [7:0] BANK_B = 8'd3;

    // action codes
    localparam logic [2:0] ACT_REGISTER   = 3'd0;
    localparam logic [2:0] ACT_LOOKUP     = 3'd1;
    localparam logic [2:0] ACT_INVALIDATE = 3'd2;
    localparam logic [2:0] ACT_PAGE_QUERY = 3'd3;
    localparam logic [2:0] ACT_FLUSH      = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
        logic [15:0] block_length;
        logic [31:0] code_handle;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] handle_out;
        logic [11:0] slot_index;
        logic [31:0] evicted_pc;
        logic [12:0] killed_count;
        logic        page_watched;
    } result_t;

    typedef struct packed {
        logic [31:0] start;
        logic [15:0] len;
        logic [31:0] handle;
    } entry_t;

    typedef struct packed {
        logic                re;
        logic [ENTRY_AW-1:0] raddr;
        logic                we;
        logic [ENTRY_AW-1:0] waddr;
        entry_t              wdata;
    } entry_port_t;

    typedef struct packed {
        logic               re;
        logic [PAGE_AW-1:0] raddr;
        logic               we;
        logic [PAGE_AW-1:0] waddr;
        logic [COUNT_W-1:0] wdata;
    } page_port_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REG_EV,
        ST_REG_DEC,
        ST_REG_NRD,
        ST_REG_INC,
        ST_LK_EV,
        ST_INV_RD,
        ST_INV_EV,
        ST_INV_PG,
        ST_PQ_EV
    } state_t;

    function automatic logic [ENTRY_AW-1:0] slot_of(input logic [31:0] pc);
        logic [31:0] h;
        begin
            h = (pc >> 1) ^ (pc >> 13);
            return h[ENTRY_AW-1:0];
        end
    endfunction

    function automatic logic [PAGE_AW-1:0] page_of(input logic [31:0] a);
        return a[PAGE_LSB+PAGE_AW-1:PAGE_LSB];
    endfunction

    function automatic logic is_watched(input entry_t e);
        logic [7:0] bank;
        begin
            bank = e.start[BANK_LSB+7:BANK_LSB];
            return (e.handle != 32'd0) && (e.len != 16'd0)
                && ((bank == BANK_A) || (bank == BANK_B));
        end
    endfunction

endpackage

>>> rtl/cbc_entry_ram.sv
// ----------------------------------------------------------------------------
// cbc_entry_ram
// block table storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cbc_entry_ram (
    input  logic                 clk,
    input  cbc_pkg::entry_port_t port,
    output cbc_pkg::entry_t      rdata
);

    cbc_pkg::entry_t mem [0:(1 << cbc_pkg::ENTRY_AW)-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (port.re)
        begin
            rdata <= mem[port.raddr];
        end
    end

endmodule

>>> rtl/cbc_page_ram.sv
// ----------------------------------------------------------------------------
// cbc_page_ram
// per-page count of watched blocks, one write and one registered read
// ----------------------------------------------------------------------------
module cbc_page_ram (
    input  logic                              clk,
    input  cbc_pkg::page_port_t               port,
    output logic [cbc_pkg::COUNT_W-1:0]       rdata
);

    logic [cbc_pkg::COUNT_W-1:0] mem [0:(1 << cbc_pkg::PAGE_AW)-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (port.re)
        begin
            rdata <= mem[port.raddr];
        end
    end

endmodule

>>> rtl/code_block_cache_smc_guard_core.sv
// ----------------------------------------------------------------------------
// code_block_cache_smc_guard_core
// direct-mapped code block table with self-modifying-code invalidation
// ----------------------------------------------------------------------------
// usage:
//   a command transfers on cmd at a clock edge with start high and busy low.
//   exactly one result per command appears on result for one cycle with
//   done high; the receiver cannot stall, so results are never held.
// steps, from the accepting edge to the cycle done is high:
//   lookup reads the table entry and page query the page count, then each
//   evaluates it; an unknown action reports straight from idle.
//   register reads the entry, then updates the page counts of the evicted
//   and the new block where watched, each a read and a write of page memory.
//   invalidate walks all 4096 table slots, a read and an evaluation per slot
//   plus a page count update per block killed; a window whose end page is
//   below its start page skips the walk. flush and reset clear all 65536
//   page memory entries, the table cleared in the same sweep; busy stays high
//   meanwhile and a flush reports its result in the cycle after the pass.
// throughput: the next command may start in the cycle done is high.
// ----------------------------------------------------------------------------
module code_block_cache_smc_guard_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cbc_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output cbc_pkg::result_t result
);

    localparam int CLR_W = cbc_pkg::PAGE_AW;

    cbc_pkg::state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic flush_pend_reg, flush_pend_next;
    logic done_reg, done_next;
    cbc_pkg::result_t res_reg, res_next;
    logic [cbc_pkg::ENTRY_AW-1:0] idx_reg, idx_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] hi_reg, hi_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] hdl_reg, hdl_next;
    logic [cbc_pkg::PAGE_AW-1:0] p0_reg, p0_next, p1_reg, p1_next;
    logic [cbc_pkg::PAGE_AW-1:0] pg_reg, pg_next;

    cbc_pkg::entry_port_t ep;
    cbc_pkg::page_port_t  pp;
    cbc_pkg::entry_t      erd;
    logic [cbc_pkg::COUNT_W-1:0] prd;

    cbc_entry_ram u_entry (.clk(clk), .port(ep), .rdata(erd));
    cbc_page_ram  u_page  (.clk(clk), .port(pp), .rdata(prd));

    logic accept;
    logic [31:0] in_lo, in_hi;
    logic [cbc_pkg::PAGE_AW-1:0] in_p0, in_p1, e_pg;
    cbc_pkg::entry_t new_e;
    logic old_w, new_w, last_idx, kill, clr_last;
    logic [31:0] e_end;
    logic [cbc_pkg::COUNT_W-1:0] prd_dec;

    assign accept = start && (state_reg == cbc_pkg::ST_IDLE);
    assign busy   = (state_reg != cbc_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // window and evaluation terms
    always_comb
    begin
        in_lo    = (cmd.address < cbc_pkg::SPAN) ? 32'd0 : cmd.address - cbc_pkg::SPAN;
        in_hi    = cmd.address + cbc_pkg::WIN;
        in_p0    = cbc_pkg::page_of(in_lo);
        in_p1    = cbc_pkg::page_of(in_hi);
        new_e    = '{start: addr_reg, len: len_reg, handle: hdl_reg};
        old_w    = cbc_pkg::is_watched(erd);
        new_w    = cbc_pkg::is_watched(new_e);
        e_pg     = cbc_pkg::page_of(erd.start);
        e_end    = erd.start + {15'd0, erd.len, 1'b0};
        kill     = old_w && (e_pg >= p0_reg) && (e_pg <= p1_reg)
                && (addr_reg < e_end) && (hi_reg > erd.start);
        last_idx = (idx_reg == {cbc_pkg::ENTRY_AW{1'b1}});
        clr_last = (clr_reg == {CLR_W{1'b1}});
        prd_dec  = (prd != '0) ? prd - 1'b1 : prd;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbc_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = cbc_pkg::ST_IDLE;
                end
            end
            cbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        cbc_pkg::ACT_REGISTER:   state_next = cbc_pkg::ST_REG_EV;
                        cbc_pkg::ACT_LOOKUP:     state_next = cbc_pkg::ST_LK_EV;
                        cbc_pkg::ACT_INVALIDATE:
                        begin
                            if (in_p1 >= in_p0)
                            begin
                                state_next = cbc_pkg::ST_INV_RD;
                            end
                        end
                        cbc_pkg::ACT_PAGE_QUERY: state_next = cbc_pkg::ST_PQ_EV;
                        cbc_pkg::ACT_FLUSH:      state_next = cbc_pkg::ST_CLEAR;
                        default:                 state_next = cbc_pkg::ST_IDLE;
                    endcase
                end
            end
            cbc_pkg::ST_REG_EV:
            begin
                if (old_w)
                begin
                    state_next = cbc_pkg::ST_REG_DEC;
                end
                else if (new_w)
                begin
                    state_next = cbc_pkg::ST_REG_INC;
                end
                else
                begin
                    state_next = cbc_pkg::ST_IDLE;
                end
            end
            cbc_pkg::ST_REG_DEC:
            begin
                state_next = new_w ? cbc_pkg::ST_REG_NRD : cbc_pkg::ST_IDLE;
            end
            cbc_pkg::ST_REG_NRD: state_next = cbc_pkg::ST_REG_INC;
            cbc_pkg::ST_REG_INC: state_next = cbc_pkg::ST_IDLE;
            cbc_pkg::ST_LK_EV:   state_next = cbc_pkg::ST_IDLE;
            cbc_pkg::ST_INV_RD:  state_next = cbc_pkg::ST_INV_EV;
            cbc_pkg::ST_INV_EV:
            begin
                if (kill)
                begin
                    state_next = cbc_pkg::ST_INV_PG;
                end
                else
                begin
                    state_next = last_idx ? cbc_pkg::ST_IDLE : cbc_pkg::ST_INV_RD;
                end
            end
            cbc_pkg::ST_INV_PG:
            begin
                state_next = last_idx ? cbc_pkg::ST_IDLE : cbc_pkg::ST_INV_RD;
            end
            cbc_pkg::ST_PQ_EV:   state_next = cbc_pkg::ST_IDLE;
            default:             state_next = cbc_pkg::ST_IDLE;
        endcase
    end

    // memory controls and datapath
    always_comb
    begin
        ep              = '0;
        pp              = '0;
        clr_next        = clr_reg;
        flush_pend_next = flush_pend_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        hi_next         = hi_reg;
        len_next        = len_reg;
        hdl_next        = hdl_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        pg_next         = pg_reg;
        case (state_reg)
            cbc_pkg::ST_CLEAR:
            begin
                ep.we    = 1'b1;
                ep.waddr = clr_reg[cbc_pkg::ENTRY_AW-1:0];
                ep.wdata = '0;
                pp.we    = 1'b1;
                pp.waddr = clr_reg;
                pp.wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_last)
                begin
                    clr_next        = '0;
                    done_next       = flush_pend_reg;
                    flush_pend_next = 1'b0;
                end
            end
            cbc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next  = '0;
                    addr_next = cmd.address;
                    hi_next   = in_hi;
                    len_next  = cmd.block_length;
                    hdl_next  = cmd.code_handle;
                    p0_next   = in_p0;
                    p1_next   = in_p1;
                    idx_next  = '0;
                    case (cmd.action)
                        cbc_pkg::ACT_REGISTER, cbc_pkg::ACT_LOOKUP:
                        begin
                            ep.re    = 1'b1;
                            ep.raddr = cbc_pkg::slot_of(cmd.address);
                            res_next.slot_index = cbc_pkg::slot_of(cmd.address);
                        end
                        cbc_pkg::ACT_INVALIDATE:
                        begin
                            done_next = (in_p1 < in_p0);
                        end
                        cbc_pkg::ACT_PAGE_QUERY:
                        begin
                            pp.re    = 1'b1;
                            pp.raddr = cbc_pkg::page_of(cmd.address);
                        end
                        cbc_pkg::ACT_FLUSH:
                        begin
                            flush_pend_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            cbc_pkg::ST_REG_EV:
            begin
                ep.we    = 1'b1;
                ep.waddr = res_reg.slot_index;
                ep.wdata = new_e;
                res_next.evicted_pc = erd.start;
                pg_next  = e_pg;
                pp.re    = 1'b1;
                pp.raddr = old_w ? e_pg : cbc_pkg::page_of(addr_reg);
                done_next = !old_w && !new_w;
            end
            cbc_pkg::ST_REG_DEC:
            begin
                pp.we     = 1'b1;
                pp.waddr  = pg_reg;
                pp.wdata  = prd_dec;
                done_next = !new_w;
            end
            cbc_pkg::ST_REG_NRD:
            begin
                pp.re    = 1'b1;
                pp.raddr = cbc_pkg::page_of(addr_reg);
            end
            cbc_pkg::ST_REG_INC:
            begin
                pp.we     = 1'b1;
                pp.waddr  = cbc_pkg::page_of(addr_reg);
                pp.wdata  = prd + 1'b1;
                done_next = 1'b1;
            end
            cbc_pkg::ST_LK_EV:
            begin
                if ((erd.start == addr_reg) && (erd.handle != 32'd0))
                begin
                    res_next.hit        = 1'b1;
                    res_next.handle_out = erd.handle;
                end
                done_next = 1'b1;
            end
            cbc_pkg::ST_INV_RD:
            begin
                ep.re    = 1'b1;
                ep.raddr = idx_reg;
            end
            cbc_pkg::ST_INV_EV:
            begin
                if (kill)
                begin
                    ep.we    = 1'b1;
                    ep.waddr = idx_reg;
                    ep.wdata = '{start: erd.start, len: erd.len, handle: 32'd0};
                    pp.re    = 1'b1;
                    pp.raddr = e_pg;
                    pg_next  = e_pg;
                    res_next.killed_count = res_reg.killed_count + 1'b1;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    done_next = last_idx;
                end
            end
            cbc_pkg::ST_INV_PG:
            begin
                pp.we     = 1'b1;
                pp.waddr  = pg_reg;
                pp.wdata  = prd_dec;
                idx_next  = idx_reg + 1'b1;
                done_next = last_idx;
            end
            cbc_pkg::ST_PQ_EV:
            begin
                res_next.page_watched = (prd != '0);
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cbc_pkg::ST_CLEAR;
            clr_reg        <= '0;
            flush_pend_reg <= 1'b0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            flush_pend_reg <= flush_pend_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        addr_reg <= addr_next;
        hi_reg   <= hi_next;
        len_reg  <= len_next;
        hdl_reg  <= hdl_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        pg_reg   <= pg_next;
    end

endmodule

>>> tb/code_block_cache_smc_guard_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_block_cache_smc_guard_core_tb
// directed and random commands against the code block table; a scoreboard
// class keeps its own copy of the table and page counts, predicts one result
// per accepted command and checks every strobed result field by field
// ----------------------------------------------------------------------------
module code_block_cache_smc_guard_core_tb;

    localparam int NUM_SLOTS  = 4096;
    localparam int NUM_PAGES  = 65536;
    localparam int STALL_MAX  = 200000;
    localparam int RAND_ITEMS = 1880;
    localparam int POOL_SIZE  = 64;

    // ------------------------------------------------------------------------
    // block table scoreboard
    // ------------------------------------------------------------------------
    class block_table_sb;
        bit [31:0]        blk_start [NUM_SLOTS];
        bit [15:0]        blk_len   [NUM_SLOTS];
        bit [31:0]        blk_handle[NUM_SLOTS];
        int unsigned      watch_cnt [NUM_PAGES];
        cbc_pkg::result_t pending_results[$];
        int               errors;

        function void wipe();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                blk_start[i]  = '0;
                blk_len[i]    = '0;
                blk_handle[i] = '0;
            end
            for (int p = 0; p < NUM_PAGES; p++)
                watch_cnt[p] = 0;
        endfunction

        function bit [11:0] hash_slot(bit [31:0] pc);
            bit [31:0] h;
            h = (pc >> 1) ^ (pc >> 13);
            return h[11:0];
        endfunction

        function bit guarded(int i);
            return blk_handle[i] != 0 && blk_len[i] != 0
                && (blk_start[i][31:24] == 8'd2 || blk_start[i][31:24] == 8'd3);
        endfunction

        // kill guarded blocks overlapping a write window
        function bit [12:0] kill_window(bit [31:0] addr);
            bit [31:0] lo;
            bit [31:0] hi;
            bit [31:0] e;
            bit [15:0] p0;
            bit [15:0] p1;
            bit [15:0] p;
            int        killed;
            killed = 0;
            lo = (addr < 32'd130) ? 32'd0 : addr - 32'd130;
            hi = addr + 32'd36;
            p0 = lo[25:10];
            p1 = hi[25:10];
            if (p1 < p0)
                return '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!guarded(i))
                    continue;
                p = blk_start[i][25:10];
                if (p < p0 || p > p1)
                    continue;
                e = blk_start[i] + {15'd0, blk_len[i], 1'b0};
                if (addr < e && hi > blk_start[i])
                begin
                    blk_handle[i] = '0;
                    if (watch_cnt[p] != 0)
                        watch_cnt[p]--;
                    killed++;
                end
            end
            return killed[12:0];
        endfunction

        // predict the result of an accepted command
        function void note_cmd(cbc_pkg::cmd_t c);
            cbc_pkg::result_t r;
            bit [11:0]        s;
            r = '0;
            case (c.action)
                cbc_pkg::ACT_REGISTER:
                begin
                    s = hash_slot(c.address);
                    r.slot_index = s;
                    r.evicted_pc = blk_start[s];
                    if (guarded(s) && watch_cnt[blk_start[s][25:10]] != 0)
                        watch_cnt[blk_start[s][25:10]]--;
                    blk_start[s]  = c.address;
                    blk_len[s]    = c.block_length;
                    blk_handle[s] = c.code_handle;
                    if (guarded(s))
                        watch_cnt[c.address[25:10]]++;
                end
                cbc_pkg::ACT_LOOKUP:
                begin
                    s = hash_slot(c.address);
                    r.slot_index = s;
                    if (blk_start[s] == c.address && blk_handle[s] != 0)
                    begin
                        r.hit        = 1'b1;
                        r.handle_out = blk_handle[s];
                    end
                end
                cbc_pkg::ACT_INVALIDATE: r.killed_count = kill_window(c.address);
                cbc_pkg::ACT_PAGE_QUERY: r.page_watched = watch_cnt[c.address[25:10]] != 0;
                cbc_pkg::ACT_FLUSH:      wipe();
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        // compare a strobed result with the oldest prediction
        function void check_result(cbc_pkg::result_t got);
            cbc_pkg::result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.hit !== exp_r.hit)
            begin
                $error("hit: expected %h actual %h", exp_r.hit, got.hit);
                errors++;
            end
            if (got.handle_out !== exp_r.handle_out)
            begin
                $error("handle_out: expected %h actual %h", exp_r.handle_out, got.handle_out);
                errors++;
            end
            if (got.slot_index !== exp_r.slot_index)
            begin
                $error("slot_index: expected %h actual %h", exp_r.slot_index, got.slot_index);
                errors++;
            end
            if (got.evicted_pc !== exp_r.evicted_pc)
            begin
                $error("evicted_pc: expected %h actual %h", exp_r.evicted_pc, got.evicted_pc);
                errors++;
            end
            if (got.killed_count !== exp_r.killed_count)
            begin
                $error("killed_count: expected %0d actual %0d",
                       exp_r.killed_count, got.killed_count);
                errors++;
            end
            if (got.page_watched !== exp_r.page_watched)
            begin
                $error("page_watched: expected %h actual %h",
                       exp_r.page_watched, got.page_watched);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    cbc_pkg::cmd_t    cmd;
    logic             busy;
    logic             done;
    cbc_pkg::result_t result;

    block_table_sb sb;
    int            idle_pct;
    int            quiet_cycles;
    bit [31:0]     pc_pool[POOL_SIZE];

    code_block_cache_smc_guard_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // monitor both transfer points
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_cmd(cmd);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // drive one command, with an optional gap, and wait for its transfer
    task automatic issue(input logic [2:0] act, input logic [31:0] addr,
                         input logic [15:0] len, input logic [31:0] hdl);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start              <= 1'b1;
        cmd.action         <= act;
        cmd.address        <= addr;
        cmd.block_length   <= len;
        cmd.code_handle    <= hdl;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    function automatic bit [31:0] pick_pc();
        if ($urandom_range(0, 99) < 80)
            return pc_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic bit [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(1, 40));
        if (r < 78)
            return 16'd0;
        if (r < 84)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    initial
    begin
        int r;
        bit [31:0] a;
        sb = new();
        sb.wipe();
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        idle_pct     = 0;
        quiet_cycles = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            pc_pool[i] = {7'd1, 1'($urandom()), 24'd0}
                       + ($urandom_range(0, 15) << 10) + ($urandom_range(0, 511) << 1);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: misses, hits, evictions, bank and length corners
        issue(cbc_pkg::ACT_LOOKUP,     32'h0200_0100, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_REGISTER,   32'h0200_0100, 16'd8,    32'h1234_5678);
        issue(cbc_pkg::ACT_LOOKUP,     32'h0200_0100, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_PAGE_QUERY, 32'h0200_0000, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_PAGE_QUERY, 32'h0200_0400, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_REGISTER,   32'h0300_2100, 16'd0,    32'hDEAD_BEEF);
        issue(cbc_pkg::ACT_REGISTER,   32'h0200_0100 ^ 32'h0000_2002, 16'd4, 32'h1);
        issue(cbc_pkg::ACT_REGISTER,   32'h0400_0200, 16'd4,    32'h5);
        issue(cbc_pkg::ACT_REGISTER,   32'h0300_0800, 16'd16,   32'd0);
        issue(cbc_pkg::ACT_REGISTER,   32'h0300_0900, 16'd16,   32'h77);
        issue(cbc_pkg::ACT_INVALIDATE, 32'h0300_0910, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_LOOKUP,     32'h0300_0900, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_REGISTER,   32'h0000_0010, 16'd4,    32'h9);
        issue(cbc_pkg::ACT_INVALIDATE, 32'h0000_0000, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_INVALIDATE, 32'hFFFF_FFF0, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        issue(cbc_pkg::ACT_LOOKUP,     32'hFFFF_FFFF, 16'd0,    32'd0);
        issue(3'd5,                    32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        issue(3'd6,                    32'h0200_0100, 16'd1,    32'd1);
        issue(3'd7,                    32'd0,         16'd0,    32'd0);
        issue(cbc_pkg::ACT_FLUSH,      32'd0,         16'd0,    32'd0);
        issue(cbc_pkg::ACT_LOOKUP,     32'h0200_0100, 16'd0,    32'd0);
        issue(cbc_pkg::ACT_PAGE_QUERY, 32'h0200_0000, 16'd0,    32'd0);

        // random: mostly pooled guarded pcs so hits and kills are common
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            case (n * 4 / RAND_ITEMS)
                0:       idle_pct = 0;
                1:       idle_pct = 45;
                2:       idle_pct = 0;
                default: idle_pct = 10;
            endcase
            r = $urandom_range(0, 999);
            if (r < 420)
                issue(cbc_pkg::ACT_REGISTER, pick_pc(), pick_len(),
                      ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom());
            else if (r < 720)
                issue(cbc_pkg::ACT_LOOKUP, pick_pc(), 16'($urandom()), $urandom());
            else if (r < 940)
                issue(cbc_pkg::ACT_PAGE_QUERY, pick_pc() ^ ($urandom_range(0, 1) << 10),
                      16'($urandom()), $urandom());
            else if (r < 970)
                issue(3'($urandom_range(5, 7)), $urandom(), 16'($urandom()), $urandom());
            else if (r < 998)
            begin
                a = pick_pc() + $urandom_range(0, 120) - 32'd40;
                issue(cbc_pkg::ACT_INVALIDATE, a, 16'($urandom()), $urandom());
            end
            else
                issue(cbc_pkg::ACT_FLUSH, $urandom(), 16'($urandom()), $urandom());
        end

        @(negedge clk);
        start <= 1'b0;

        // drain
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cbc_pkg.sv
rtl/cbc_entry_ram.sv
rtl/cbc_page_ram.sv
rtl/code_block_cache_smc_guard_core.sv
tb/code_block_cache_smc_guard_core_tb.sv
